>>> rtl/core/trbd_pkg.sv
// Shared types, constants and codes for the tight rectangle byte decoder.
package trbd_pkg;

    // Sizing constants.
    localparam int PALETTE_DEPTH = 256;
    localparam int COORD_BITS    = 12;
    localparam int ADDRESS_BITS  = 24;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int LEN_BITS      = 22;
    localparam int QUEUE_DEPTH   = 4;
    localparam int Q_AW          = $clog2(QUEUE_DEPTH);
    localparam int FW_BITS       = COORD_BITS + 1;
    localparam int ROWBASE_BITS  = 2 * FW_BITS;
    localparam int SIZE_BITS     = 2 * COORD_BITS + 3;

    // Control byte codes (high nibble) and the palette filter code.
    localparam logic [3:0] CTRL_FILL      = 4'h8;
    localparam logic [3:0] CTRL_JPEG      = 4'h9;
    localparam logic [7:0] FILTER_PALETTE = 8'h01;

    // Error codes.
    localparam logic ERR_JPEG    = 1'b0;
    localparam logic ERR_INVALID = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_RECT_LEFT   = 3'd0;
    localparam logic [2:0] REG_RECT_TOP    = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FRAME_WIDTH = 3'd4;
    localparam logic [2:0] REG_COMP_FLOOR  = 3'd5;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_PIXEL    = 3'd0,
        KIND_FILL     = 3'd1,
        KIND_COMP     = 3'd2,
        KIND_RESETS   = 3'd3,
        KIND_ERROR    = 3'd4,
        KIND_RECT_END = 3'd5
    } t_kind;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_CTRL, PH_FILL, PH_FILTER, PH_NCOLORS, PH_PALETTE, PH_RAW,
        PH_INDEXED, PH_LEN1, PH_LEN2, PH_LEN3, PH_COMP, PH_HALT
    } t_phase;

    // Main operation of a queued command.
    typedef enum logic [2:0] {
        OP_NONE, OP_PIX, OP_PIX8, OP_BITS, OP_FILL, OP_COMP, OP_ERR
    } t_op;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE, B_RST, B_PREP, B_MAIN, B_END
    } t_bstate;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [FW_BITS-1:0]    fwidth;
        logic [7:0]            floor_size;
    } t_cfg;

    // One classified input byte, handed from front to back.
    typedef struct packed {
        logic [3:0]            rst_mask;
        t_op                   op;
        logic                  rect_end;
        logic [23:0]           data;
        logic [3:0]            count;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [1:0]            sid;
        logic                  pp;
        logic                  pe;
        logic                  ec;
    } t_cmd;

    // Palette write port.
    typedef struct packed {
        logic        we;
        logic [7:0]  idx;
        logic [23:0] data;
    } t_palw;

    // Back end status seen by the front.
    typedef struct packed {
        logic idle;
    } t_bstat;

endpackage

>>> rtl/core/trbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trbd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/trbd_queue.sv
// Short command queue between the parser front and the result back end.
module trbd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trbd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output trbd_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import trbd_pkg::*;

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;

    // Pointer and fill count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_AW+1)'(QUEUE_DEPTH));
endmodule

>>> rtl/core/trbd_front.sv
// Parser front end: accepts stream bytes, tracks phase and emits commands.
module trbd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  trbd_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_q_full,
    input  logic            i_q_empty,
    input  trbd_pkg::t_bstat i_bstat,
    output logic            o_push,
    output trbd_pkg::t_cmd  o_cmd,
    output trbd_pkg::t_palw o_palw
);
    import trbd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_stream, n_stream;
    logic                  r_pmode, n_pmode;
    logic [8:0]            r_ccount, n_ccount;
    logic [15:0]           r_asm, n_asm;
    logic [1:0]            r_cnt, n_cnt;
    logic [7:0]            r_pidx, n_pidx;
    logic [LEN_BITS-1:0]   r_len, n_len;
    logic [LEN_BITS-1:0]   r_bcnt, n_bcnt;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;

    logic                  accept;
    logic                  hdr_pm;
    logic [FW_BITS-1:0]    hdr_m;
    logic [SIZE_BITS-1:0]  hdr_prod;
    logic [SIZE_BITS-1:0]  hdr_size;
    logic                  hdr_small;
    logic                  hdr_zero;
    logic                  pix_bits;
    logic [FW_BITS-1:0]    pix_diff;
    logic [3:0]            pix_k;
    logic                  pix_rowend;
    logic [COORD_BITS-1:0] pix_rownext;
    logic                  pix_rectend;

    // Palette bytes wait until the back end no longer reads the palette.
    always_comb begin
        o_ready = !i_q_full;
        if (r_phase == PH_PALETTE && !(i_q_empty && i_bstat.idle)) begin
            o_ready = 1'b0;
        end
    end
    assign accept = i_valid && o_ready;

    // Payload size check that decides raw data against a length header.
    always_comb begin
        hdr_pm = (r_phase == PH_PALETTE);
        if (hdr_pm && r_ccount <= 9'd2) begin
            hdr_m = (FW_BITS'(i_cfg.width) + FW_BITS'(7)) >> 3;
        end else begin
            hdr_m = FW_BITS'(i_cfg.width);
        end
        hdr_prod = SIZE_BITS'(hdr_m) * SIZE_BITS'(i_cfg.height);
        hdr_size = hdr_pm ? hdr_prod : (hdr_prod + (hdr_prod << 1));
        hdr_small = hdr_size < SIZE_BITS'(i_cfg.floor_size);
        hdr_zero  = (hdr_prod == '0);
    end

    // Pixels this byte yields before its row ends, and where that leaves us.
    always_comb begin
        pix_bits = (r_phase == PH_INDEXED) && (r_ccount <= 9'd2);
        pix_diff = FW_BITS'(i_cfg.width) - FW_BITS'(r_col);
        if (!pix_bits || i_cfg.width <= r_col) begin
            pix_k      = 4'd1;
            pix_rowend = (FW_BITS'(r_col) + FW_BITS'(1)) >= FW_BITS'(i_cfg.width);
        end else begin
            pix_k      = (pix_diff >= FW_BITS'(8)) ? 4'd8 : pix_diff[3:0];
            pix_rowend = (pix_diff <= FW_BITS'(8));
        end
        pix_rownext = r_row + 1'b1;
        pix_rectend = pix_rowend && (pix_rownext >= i_cfg.height);
    end

    // Phase machine: next state and command for the accepted byte.
    always_comb begin
        n_phase  = r_phase;
        n_stream = r_stream;
        n_pmode  = r_pmode;
        n_ccount = r_ccount;
        n_asm    = r_asm;
        n_cnt    = r_cnt;
        n_pidx   = r_pidx;
        n_len    = r_len;
        n_bcnt   = r_bcnt;
        n_col    = r_col;
        n_row    = r_row;
        o_push   = 1'b0;
        o_cmd    = '0;
        o_cmd.op = OP_NONE;
        o_palw   = '0;
        if (accept) begin
            case (r_phase)
                PH_CTRL: begin
                    o_cmd.rst_mask = i_data_byte[3:0];
                    o_push = (i_data_byte[3:0] != 4'd0);
                    if (i_data_byte[7:4] == CTRL_FILL) begin
                        n_cnt   = 2'd0;
                        n_asm   = '0;
                        n_phase = PH_FILL;
                    end else if (i_data_byte[7:4] >= CTRL_JPEG) begin
                        o_cmd.op = OP_ERR;
                        o_cmd.ec = (i_data_byte[7:4] == CTRL_JPEG) ? ERR_JPEG : ERR_INVALID;
                        o_push   = 1'b1;
                        n_phase  = PH_HALT;
                    end else begin
                        n_stream = i_data_byte[5:4];
                        if (i_data_byte[6]) begin
                            n_phase = PH_FILTER;
                        end else begin
                            n_pmode = 1'b0;
                            if (hdr_small) begin
                                n_asm = '0;
                                n_cnt = 2'd0;
                                n_col = '0;
                                n_row = '0;
                                if (hdr_zero) begin
                                    o_cmd.rect_end = 1'b1;
                                    o_push  = 1'b1;
                                    n_phase = PH_CTRL;
                                end else begin
                                    n_phase = PH_RAW;
                                end
                            end else begin
                                n_phase = PH_LEN1;
                            end
                        end
                    end
                end
                PH_FILL: begin
                    if (r_cnt < 2'd2) begin
                        n_asm = {r_asm[7:0], i_data_byte};
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        o_cmd.op       = OP_FILL;
                        o_cmd.data     = {r_asm, i_data_byte};
                        o_cmd.rect_end = 1'b1;
                        o_push  = 1'b1;
                        n_phase = PH_CTRL;
                    end
                end
                PH_FILTER: begin
                    if (i_data_byte == FILTER_PALETTE) begin
                        n_pmode = 1'b1;
                        n_phase = PH_NCOLORS;
                    end else begin
                        n_pmode = 1'b0;
                        if (hdr_small) begin
                            n_asm = '0;
                            n_cnt = 2'd0;
                            n_col = '0;
                            n_row = '0;
                            if (hdr_zero) begin
                                o_cmd.rect_end = 1'b1;
                                o_push  = 1'b1;
                                n_phase = PH_CTRL;
                            end else begin
                                n_phase = PH_RAW;
                            end
                        end else begin
                            n_phase = PH_LEN1;
                        end
                    end
                end
                PH_NCOLORS: begin
                    n_ccount = {1'b0, i_data_byte} + 9'd1;
                    n_cnt    = 2'd0;
                    n_pidx   = '0;
                    n_asm    = '0;
                    n_phase  = PH_PALETTE;
                end
                PH_PALETTE: begin
                    if (r_cnt < 2'd2) begin
                        n_asm = {r_asm[7:0], i_data_byte};
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        o_palw.we   = ({1'b0, r_pidx} < 9'(PALETTE_DEPTH));
                        o_palw.idx  = r_pidx;
                        o_palw.data = {r_asm, i_data_byte};
                        n_cnt  = 2'd0;
                        n_pidx = r_pidx + 1'b1;
                        // The last color of the palette closes the header.
                        if ({1'b0, r_pidx} + 9'd1 == r_ccount) begin
                            if (hdr_small) begin
                                n_asm = '0;
                                n_cnt = 2'd0;
                                n_col = '0;
                                n_row = '0;
                                if (hdr_zero) begin
                                    o_cmd.rect_end = 1'b1;
                                    o_push  = 1'b1;
                                    n_phase = PH_CTRL;
                                end else begin
                                    n_phase = PH_INDEXED;
                                end
                            end else begin
                                n_phase = PH_LEN1;
                            end
                        end
                    end
                end
                PH_RAW, PH_INDEXED: begin
                    if (r_phase == PH_RAW && r_cnt < 2'd2) begin
                        n_asm = {r_asm[7:0], i_data_byte};
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_cnt = 2'd0;
                        if (r_phase == PH_RAW) begin
                            o_cmd.op   = OP_PIX;
                            o_cmd.data = {r_asm, i_data_byte};
                        end else begin
                            o_cmd.op   = pix_bits ? OP_BITS : OP_PIX8;
                            o_cmd.data = {16'd0, i_data_byte};
                        end
                        o_cmd.count    = pix_k;
                        o_cmd.col      = r_col;
                        o_cmd.row      = r_row;
                        o_cmd.rect_end = pix_rectend;
                        o_push = 1'b1;
                        if (pix_rowend) begin
                            n_col = '0;
                            n_row = pix_rownext;
                            if (pix_rectend) begin
                                n_phase = PH_CTRL;
                            end
                        end else begin
                            n_col = r_col + COORD_BITS'(pix_k);
                        end
                    end
                end
                PH_LEN1, PH_LEN2, PH_LEN3: begin
                    if (r_phase == PH_LEN1) begin
                        n_len = LEN_BITS'(i_data_byte[6:0]);
                    end else if (r_phase == PH_LEN2) begin
                        n_len = r_len | (LEN_BITS'(i_data_byte[6:0]) << 7);
                    end else begin
                        n_len = r_len | (LEN_BITS'(i_data_byte) << 14);
                    end
                    if (r_phase == PH_LEN1 && i_data_byte[7]) begin
                        n_phase = PH_LEN2;
                    end else if (r_phase == PH_LEN2 && i_data_byte[7]) begin
                        n_phase = PH_LEN3;
                    end else begin
                        n_bcnt = '0;
                        if (n_len == '0) begin
                            o_cmd.rect_end = 1'b1;
                            o_push  = 1'b1;
                            n_phase = PH_CTRL;
                        end else begin
                            n_phase = PH_COMP;
                        end
                    end
                end
                PH_COMP: begin
                    n_bcnt     = r_bcnt + 1'b1;
                    o_cmd.op   = OP_COMP;
                    o_cmd.data = {16'd0, i_data_byte};
                    o_cmd.sid  = r_stream;
                    o_cmd.pp   = r_pmode;
                    o_push     = 1'b1;
                    if (n_bcnt == r_len) begin
                        o_cmd.pe       = 1'b1;
                        o_cmd.rect_end = 1'b1;
                        n_phase = PH_CTRL;
                    end
                end
                default: begin
                    // Halted after an error: bytes are taken and dropped.
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CTRL;
            r_stream <= '0;
            r_pmode  <= 1'b0;
            r_ccount <= '0;
            r_asm    <= '0;
            r_cnt    <= '0;
            r_pidx   <= '0;
            r_len    <= '0;
            r_bcnt   <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_stream <= n_stream;
            r_pmode  <= n_pmode;
            r_ccount <= n_ccount;
            r_asm    <= n_asm;
            r_cnt    <= n_cnt;
            r_pidx   <= n_pidx;
            r_len    <= n_len;
            r_bcnt   <= n_bcnt;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end
endmodule

>>> rtl/core/trbd_back.sv
// Result back end: expands queued commands into output beats.
module trbd_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  trbd_pkg::t_cfg           i_cfg,
    input  trbd_pkg::t_cmd           i_cmd,
    input  logic                     i_q_empty,
    output logic                     o_pop,
    output trbd_pkg::t_bstat         o_bstat,
    input  trbd_pkg::t_palw          i_palw,
    output logic                     o_ram_re,
    output logic [trbd_pkg::PAL_AW-1:0] o_ram_raddr,
    input  logic [23:0]              i_ram_rdata,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2:0]               o_kind,
    output logic [trbd_pkg::ADDRESS_BITS-1:0] o_pixel_address,
    output logic [23:0]              o_color,
    output logic [7:0]               o_payload_byte,
    output logic [1:0]               o_stream_id,
    output logic                     o_palette_payload,
    output logic [3:0]               o_reset_mask,
    output logic                     o_error_code,
    output logic                     o_payload_end,
    output logic                     o_last
);
    import trbd_pkg::*;

    t_bstate                 r_state, n_state;
    t_cmd                    r_cmd;
    logic [ROWBASE_BITS-1:0] r_rowbase;
    logic [2:0]              r_k, n_k;
    logic [PALETTE_DEPTH-1:0] r_pvalid;
    logic [23:0]             r_pal0;
    logic [23:0]             r_pal1;

    logic                    r_o_valid;
    logic [2:0]              r_o_kind;
    logic [ADDRESS_BITS-1:0] r_o_addr;
    logic [23:0]             r_o_color;
    logic [7:0]              r_o_pbyte;
    logic [1:0]              r_o_sid;
    logic                    r_o_pp;
    logic [3:0]              r_o_mask;
    logic                    r_o_ec;
    logic                    r_o_pe;
    logic                    r_o_last;

    logic                    out_free;
    logic                    emit;
    t_kind                   e_kind;
    logic [ADDRESS_BITS-1:0] e_addr;
    logic [23:0]             e_color;
    logic [7:0]              e_pbyte;
    logic [1:0]              e_sid;
    logic                    e_pp;
    logic [3:0]              e_mask;
    logic                    e_ec;
    logic                    e_pe;
    logic                    e_last;
    logic                    is_pix;
    logic                    pix_last;
    logic [2:0]              bsel;
    logic                    idx_ok;
    logic [23:0]             pix_color;

    assign out_free      = !r_o_valid || i_ready;
    assign o_pop         = (r_state == B_IDLE) && !i_q_empty;
    assign o_bstat.idle  = (r_state == B_IDLE);
    assign o_ram_re      = (r_state == B_PREP);
    assign o_ram_raddr   = r_cmd.data[PAL_AW-1:0];

    // Pixel color for the current pixel of the command.
    always_comb begin
        is_pix   = (r_cmd.op == OP_PIX) || (r_cmd.op == OP_PIX8) || (r_cmd.op == OP_BITS);
        pix_last = ({1'b0, r_k} + 4'd1) == r_cmd.count;
        bsel     = 3'd7 - r_k;
        idx_ok   = {1'b0, r_cmd.data[7:0]} < 9'(PALETTE_DEPTH);
        case (r_cmd.op)
            OP_BITS:  pix_color = r_cmd.data[bsel] ? r_pal1 : r_pal0;
            OP_PIX8:  pix_color = (idx_ok && r_pvalid[r_cmd.data[PAL_AW-1:0]]) ?
                                  i_ram_rdata : 24'd0;
            default:  pix_color = r_cmd.data;
        endcase
    end

    // Sequencer: stream resets, then the main results, then rectangle end.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        emit    = 1'b0;
        e_kind  = KIND_PIXEL;
        e_addr  = '0;
        e_color = '0;
        e_pbyte = '0;
        e_sid   = '0;
        e_pp    = 1'b0;
        e_mask  = '0;
        e_ec    = 1'b0;
        e_pe    = 1'b0;
        e_last  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    if (i_cmd.rst_mask != 4'd0) begin
                        n_state = B_RST;
                    end else if (i_cmd.op == OP_PIX || i_cmd.op == OP_PIX8 ||
                                 i_cmd.op == OP_BITS) begin
                        n_state = B_PREP;
                    end else if (i_cmd.op != OP_NONE) begin
                        n_state = B_MAIN;
                    end else begin
                        n_state = B_END;
                    end
                end
            end
            B_RST: begin
                emit   = out_free;
                e_kind = KIND_RESETS;
                e_mask = r_cmd.rst_mask;
                e_last = (r_cmd.op == OP_NONE) && !r_cmd.rect_end;
                if (out_free) begin
                    if (is_pix) begin
                        n_state = B_PREP;
                    end else if (r_cmd.op != OP_NONE) begin
                        n_state = B_MAIN;
                    end else if (r_cmd.rect_end) begin
                        n_state = B_END;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_PREP: begin
                n_k     = '0;
                n_state = B_MAIN;
            end
            B_MAIN: begin
                emit = out_free;
                case (r_cmd.op)
                    OP_FILL: begin
                        e_kind  = KIND_FILL;
                        e_color = r_cmd.data;
                    end
                    OP_COMP: begin
                        e_kind  = KIND_COMP;
                        e_pbyte = r_cmd.data[7:0];
                        e_sid   = r_cmd.sid;
                        e_pp    = r_cmd.pp;
                        e_pe    = r_cmd.pe;
                    end
                    OP_ERR: begin
                        e_kind = KIND_ERROR;
                        e_ec   = r_cmd.ec;
                    end
                    default: begin
                        e_kind  = KIND_PIXEL;
                        e_color = pix_color;
                        e_addr  = ADDRESS_BITS'(r_rowbase) + ADDRESS_BITS'(i_cfg.left)
                                + ADDRESS_BITS'(r_cmd.col) + ADDRESS_BITS'(r_k);
                    end
                endcase
                e_last = !r_cmd.rect_end && (!is_pix || pix_last);
                if (out_free) begin
                    if (is_pix && !pix_last) begin
                        n_k = r_k + 1'b1;
                    end else begin
                        n_state = r_cmd.rect_end ? B_END : B_IDLE;
                    end
                end
            end
            B_END: begin
                emit   = out_free;
                e_kind = KIND_RECT_END;
                e_last = 1'b1;
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Sequencer control registers and palette bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_k       <= '0;
            r_o_valid <= 1'b0;
            r_pvalid  <= '0;
            r_pal0    <= '0;
            r_pal1    <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_palw.we) begin
                r_pvalid[i_palw.idx[PAL_AW-1:0]] <= 1'b1;
                if (i_palw.idx == 8'd0) begin
                    r_pal0 <= i_palw.data;
                end
                if (i_palw.idx == 8'd1) begin
                    r_pal1 <= i_palw.data;
                end
            end
        end
    end

    // Command capture, row base product and the output register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == B_PREP) begin
            r_rowbase <= ROWBASE_BITS'(FW_BITS'(i_cfg.top) + FW_BITS'(r_cmd.row))
                       * ROWBASE_BITS'(i_cfg.fwidth);
        end
        if (emit) begin
            r_o_kind  <= e_kind;
            r_o_addr  <= e_addr;
            r_o_color <= e_color;
            r_o_pbyte <= e_pbyte;
            r_o_sid   <= e_sid;
            r_o_pp    <= e_pp;
            r_o_mask  <= e_mask;
            r_o_ec    <= e_ec;
            r_o_pe    <= e_pe;
            r_o_last  <= e_last;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_kind            = r_o_kind;
    assign o_pixel_address   = r_o_addr;
    assign o_color           = r_o_color;
    assign o_payload_byte    = r_o_pbyte;
    assign o_stream_id       = r_o_sid;
    assign o_palette_payload = r_o_pp;
    assign o_reset_mask      = r_o_mask;
    assign o_error_code      = r_o_ec;
    assign o_payload_end     = r_o_pe;
    assign o_last            = r_o_last;
endmodule

>>> rtl/core/tight_rect_byte_decoder_top.sv
// Top level of the tight rectangle byte decoder with its register port.
//
// Input channel: one byte of a Tight rectangle per beat (i_valid, o_ready,
// i_data_byte). Output channel: one result per beat (o_valid, i_ready) with
// kind, pixel address, color, compressed byte and its tags, stream reset
// mask, error code and a last flag on the final result of each input byte.
// Registers (rectangle position and size, row stride, compress floor) are
// written over the APB port; the user must write them only while the block
// is idle, which the block itself does not enforce. Header and control
// bytes are taken one per cycle while o_ready is high. A byte that causes
// results enters a four-entry command queue; the back end sequencer pops
// it, emits any stream resets, passes pixel commands through a prepare step
// (row base multiply and palette RAM read) and then emits its results. A
// raw pixel needs three input bytes, an 8-bit index byte yields one pixel
// and a packed 1-bit byte up to eight pixel writes. When the receiver
// stalls, the output register holds its beat, the queue fills and then
// o_ready drops. Palette bytes wait until the back end drains.
// Reset returns the parser to expect a control byte, empties the queue,
// clears the palette and loads the register defaults.
module tight_rect_byte_decoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0]                         o_kind,
    output logic [trbd_pkg::ADDRESS_BITS-1:0]  o_pixel_address,
    output logic [23:0]                        o_color,
    output logic [7:0]                         o_payload_byte,
    output logic [1:0]                         o_stream_id,
    output logic                               o_palette_payload,
    output logic [3:0]                         o_reset_mask,
    output logic                               o_error_code,
    output logic                               o_payload_end,
    output logic                               o_last
);
    import trbd_pkg::*;

    t_cfg              r_cfg;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;
    logic              push;
    logic              pop;
    t_cmd              cmd_in;
    t_cmd              cmd_out;
    logic              q_empty;
    logic              q_full;
    t_bstat            bstat;
    t_palw             palw;
    logic              ram_re;
    logic [PAL_AW-1:0] ram_raddr;
    logic [23:0]       ram_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left       <= '0;
            r_cfg.top        <= '0;
            r_cfg.width      <= COORD_BITS'(1);
            r_cfg.height     <= COORD_BITS'(1);
            r_cfg.fwidth     <= FW_BITS'(1024);
            r_cfg.floor_size <= 8'd12;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RECT_LEFT:   r_cfg.left       <= pwdata[COORD_BITS-1:0];
                REG_RECT_TOP:    r_cfg.top        <= pwdata[COORD_BITS-1:0];
                REG_RECT_WIDTH:  r_cfg.width      <= pwdata[COORD_BITS-1:0];
                REG_RECT_HEIGHT: r_cfg.height     <= pwdata[COORD_BITS-1:0];
                REG_FRAME_WIDTH: r_cfg.fwidth     <= pwdata[FW_BITS-1:0];
                REG_COMP_FLOOR:  r_cfg.floor_size <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (cfg_idx)
            REG_RECT_LEFT:   prdata = 32'(r_cfg.left);
            REG_RECT_TOP:    prdata = 32'(r_cfg.top);
            REG_RECT_WIDTH:  prdata = 32'(r_cfg.width);
            REG_RECT_HEIGHT: prdata = 32'(r_cfg.height);
            REG_FRAME_WIDTH: prdata = 32'(r_cfg.fwidth);
            REG_COMP_FLOOR:  prdata = 32'(r_cfg.floor_size);
            default:         prdata = 32'd0;
        endcase
    end

    trbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .i_bstat     (bstat),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .o_palw      (palw)
    );

    trbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    trbd_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (palw.we),
        .i_waddr (palw.idx[PAL_AW-1:0]),
        .i_wdata (palw.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    trbd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (cmd_out),
        .i_q_empty         (q_empty),
        .o_pop             (pop),
        .o_bstat           (bstat),
        .i_palw            (palw),
        .o_ram_re          (ram_re),
        .o_ram_raddr       (ram_raddr),
        .i_ram_rdata       (ram_rdata),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_kind            (o_kind),
        .o_pixel_address   (o_pixel_address),
        .o_color           (o_color),
        .o_payload_byte    (o_payload_byte),
        .o_stream_id       (o_stream_id),
        .o_palette_payload (o_palette_payload),
        .o_reset_mask      (o_reset_mask),
        .o_error_code      (o_error_code),
        .o_payload_end     (o_payload_end),
        .o_last            (o_last)
    );
endmodule

>>> bench/tb.sv
// Self-checking testbench for the tight rectangle byte decoder.
`timescale 1ns / 1ps

module tb;
    import trbd_pkg::*;

    // One result beat as seen on the output channel.
    typedef struct packed {
        t_kind       kind;
        logic [23:0] addr;
        logic [23:0] color;
        logic [7:0]  pbyte;
        logic [1:0]  sid;
        logic        pp;
        logic [3:0]  rmask;
        logic        ec;
        logic        pend;
        logic        last;
    } beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [ADDRESS_BITS-1:0] o_pixel_address;
    logic [23:0] o_color;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_stream_id;
    logic        o_palette_payload;
    logic [3:0]  o_reset_mask;
    logic        o_error_code;
    logic        o_payload_end;
    logic        o_last;

    tight_rect_byte_decoder_top dut (.*);

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Register copy and parser state of the predictor.
    logic [11:0] cfg_left = 0, cfg_top = 0, cfg_width = 1, cfg_height = 1;
    logic [12:0] cfg_fwidth = 1024;
    logic [7:0]  cfg_floor = 12;
    t_phase      st_phase = PH_CTRL;
    logic [1:0]  st_stream = 0;
    logic        st_palmode = 0;
    int unsigned st_ncolors = 0;
    logic [23:0] st_palette [PALETTE_DEPTH];
    logic [15:0] st_assembly = 0;
    int unsigned st_count = 0;
    int unsigned st_length = 0;
    logic [11:0] st_col = 0, st_row = 0;

    logic [7:0] byte_queue [$];
    beat_t      expected_beats [$];
    beat_t      byte_beats [$];
    bit         calm = 0;
    int         mismatches = 0;
    int         stall_cycles = 0;

    initial begin
        for (int k = 0; k < PALETTE_DEPTH; k++) st_palette[k] = '0;
    end

    // Queues one result of the byte being predicted.
    function automatic void emit(t_kind k, logic [23:0] a, logic [23:0] c,
                                 logic [7:0] pb, logic [1:0] s, logic p,
                                 logic [3:0] m, logic e, logic pe);
        beat_t r;
        r = '{k, a, c, pb, s, p, m, e, pe, 1'b0};
        if (byte_beats.size() < 9) byte_beats.push_back(r);
    endfunction

    function automatic void close_rect();
        emit(KIND_RECT_END, 0, 0, 0, 0, 0, 0, 0, 0);
        st_phase = PH_CTRL;
    endfunction

    function automatic logic [23:0] palette_color(int unsigned idx);
        return idx < PALETTE_DEPTH ? st_palette[idx] : 24'd0;
    endfunction

    // Writes one pixel; returns 1 at a row end and 2 at the rectangle end.
    function automatic int write_pixel(logic [23:0] c);
        logic [63:0] a;
        a = (64'(cfg_top) + st_row) * cfg_fwidth + cfg_left + st_col;
        emit(KIND_PIXEL, a[23:0], c, 0, 0, 0, 0, 0, 0);
        st_col = st_col + 1;
        if (st_col < cfg_width) return 0;
        st_col = 0;
        st_row = st_row + 1;
        if (st_row < cfg_height) return 1;
        close_rect();
        return 2;
    endfunction

    // Payload size in bytes that follows the header of a basic rectangle.
    function automatic longint unsigned payload_size(logic pal, int unsigned ncol);
        longint unsigned w, h;
        w = cfg_width;
        h = cfg_height;
        if (pal) return h * (ncol <= 2 ? (w + 7) / 8 : w);
        return w * h * 3;
    endfunction

    function automatic void header_done();
        longint unsigned size;
        size = payload_size(st_palmode, st_ncolors);
        if (size < cfg_floor) begin
            st_count = 0;
            st_assembly = 0;
            st_col = 0;
            st_row = 0;
            // An empty raw payload closes the rectangle at once.
            if (size == 0) close_rect();
            else st_phase = st_palmode ? PH_INDEXED : PH_RAW;
        end else begin
            st_phase = PH_LEN1;
        end
    endfunction

    function automatic void length_done();
        st_count = 0;
        if (st_length == 0) close_rect();
        else st_phase = PH_COMP;
    endfunction

    // Predicts the results of one accepted byte.
    function automatic void predict_byte(logic [7:0] b);
        logic [3:0] hi;
        int r;
        byte_beats.delete();
        hi = b[7:4];
        case (st_phase)
            PH_CTRL: begin
                if (b[3:0] != 0) emit(KIND_RESETS, 0, 0, 0, 0, 0, b[3:0], 0, 0);
                if (hi == CTRL_FILL) begin
                    st_count = 0;
                    st_assembly = 0;
                    st_phase = PH_FILL;
                end else if (hi == CTRL_JPEG) begin
                    emit(KIND_ERROR, 0, 0, 0, 0, 0, 0, ERR_JPEG, 0);
                    st_phase = PH_HALT;
                end else if (hi > CTRL_JPEG) begin
                    emit(KIND_ERROR, 0, 0, 0, 0, 0, 0, ERR_INVALID, 0);
                    st_phase = PH_HALT;
                end else begin
                    st_stream = hi[1:0];
                    if (hi[2]) begin
                        st_phase = PH_FILTER;
                    end else begin
                        st_palmode = 0;
                        header_done();
                    end
                end
            end
            PH_FILL: begin
                if (st_count < 2) begin
                    st_assembly = {st_assembly[7:0], b};
                    st_count++;
                end else begin
                    emit(KIND_FILL, 0, {st_assembly, b}, 0, 0, 0, 0, 0, 0);
                    close_rect();
                end
            end
            PH_FILTER: begin
                if (b == FILTER_PALETTE) begin
                    st_palmode = 1;
                    st_phase = PH_NCOLORS;
                end else begin
                    st_palmode = 0;
                    header_done();
                end
            end
            PH_NCOLORS: begin
                st_ncolors = b + 1;
                st_count = 0;
                st_assembly = 0;
                st_phase = PH_PALETTE;
            end
            PH_PALETTE: begin
                if (st_count % 3 < 2) st_assembly = {st_assembly[7:0], b};
                else if (st_count / 3 < PALETTE_DEPTH)
                    st_palette[st_count / 3] = {st_assembly, b};
                st_count++;
                if (st_count >= st_ncolors * 3) header_done();
            end
            PH_RAW: begin
                if (st_count < 2) begin
                    st_assembly = {st_assembly[7:0], b};
                    st_count++;
                end else begin
                    st_count = 0;
                    r = write_pixel({st_assembly, b});
                end
            end
            PH_INDEXED: begin
                if (st_ncolors <= 2) begin
                    for (int k = 7; k >= 0; k--) begin
                        r = write_pixel(palette_color(b[k]));
                        if (r != 0) break;
                    end
                end else begin
                    r = write_pixel(palette_color(b));
                end
            end
            PH_LEN1: begin
                st_length = b[6:0];
                if (b[7]) st_phase = PH_LEN2;
                else length_done();
            end
            PH_LEN2: begin
                st_length = st_length | (int'(b[6:0]) << 7);
                if (b[7]) st_phase = PH_LEN3;
                else length_done();
            end
            PH_LEN3: begin
                st_length = (st_length | (int'(b) << 14)) & 32'h3F_FFFF;
                length_done();
            end
            PH_COMP: begin
                st_count = (st_count + 1) & 32'hFF_FFFF;
                if (st_count >= st_length) begin
                    emit(KIND_COMP, 0, 0, b, st_stream, st_palmode, 0, 0, 1);
                    close_rect();
                end else begin
                    emit(KIND_COMP, 0, 0, b, st_stream, st_palmode, 0, 0, 0);
                end
            end
            default: ;
        endcase
        if (byte_beats.size() > 0) byte_beats[byte_beats.size() - 1].last = 1'b1;
        foreach (byte_beats[k]) expected_beats.push_back(byte_beats[k]);
    endfunction

    // Input driver; the predictor runs on every accepted byte.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_byte(i_data_byte);
            if (!i_valid || o_ready) begin
                if (byte_queue.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
                    i_valid <= 1'b1;
                    i_data_byte <= byte_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stalls.
    always @(posedge i_clk) begin
        beat_t got, want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = '{t_kind'(o_kind), o_pixel_address, o_color, o_payload_byte,
                        o_stream_id, o_palette_payload, o_reset_mask, o_error_code,
                        o_payload_end, o_last};
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            i_ready <= calm || $urandom_range(99) >= 24;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= 5000) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One register write over the APB port.
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RECT_LEFT:   cfg_left = value[11:0];
            REG_RECT_TOP:    cfg_top = value[11:0];
            REG_RECT_WIDTH:  cfg_width = value[11:0];
            REG_RECT_HEIGHT: cfg_height = value[11:0];
            REG_FRAME_WIDTH: cfg_fwidth = value[12:0];
            REG_COMP_FLOOR:  cfg_floor = value[7:0];
            default: ;
        endcase
    endtask

    // Waits until the block has nothing left to do.
    task automatic drain();
        while (byte_queue.size() > 0 || i_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_regs(int l, int t, int w, int h, int fw, int fl);
        drain();
        reg_write(REG_RECT_LEFT, l);
        reg_write(REG_RECT_TOP, t);
        reg_write(REG_RECT_WIDTH, w);
        reg_write(REG_RECT_HEIGHT, h);
        reg_write(REG_FRAME_WIDTH, fw);
        reg_write(REG_COMP_FLOOR, fl);
    endtask

    task automatic push_random(int n);
        repeat (n) byte_queue.push_back(8'($urandom));
    endtask

    // Queues one well-formed rectangle with random content.
    task automatic queue_rect();
        logic [3:0] mask, hi;
        logic       pal;
        int unsigned ncol, len;
        longint unsigned size;
        mask = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom);
        if ($urandom_range(99) < 12) begin
            byte_queue.push_back({CTRL_FILL, mask});
            push_random(3);
            return;
        end
        hi = 4'($urandom_range(7));
        byte_queue.push_back({hi, mask});
        pal = 0;
        ncol = 0;
        if (hi[2]) begin
            if ($urandom_range(1) == 0) begin
                pal = 1;
                byte_queue.push_back(FILTER_PALETTE);
                ncol = ($urandom_range(49) == 0) ? 256 : $urandom_range(1, 4);
                byte_queue.push_back(8'(ncol - 1));
                push_random(3 * ncol);
            end else begin
                byte_queue.push_back(($urandom_range(1) == 0) ? 8'd2 : 8'($urandom) & 8'hFE);
            end
        end
        size = payload_size(pal, ncol);
        if (size < cfg_floor) begin
            push_random(size);
            return;
        end
        len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
        case ($urandom_range(2))
            0: byte_queue.push_back(8'(len));
            1: begin
                byte_queue.push_back({1'b1, 7'(len)});
                byte_queue.push_back({1'b0, 7'(len >> 7)});
            end
            default: begin
                byte_queue.push_back({1'b1, 7'(len)});
                byte_queue.push_back({1'b1, 7'(len >> 7)});
                byte_queue.push_back(8'(len >> 14));
            end
        endcase
        push_random(len);
    endtask

    // Reset, directed bytes, random phases, then the closing error code.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fills at both color extremes, the first with every stream reset requested, then raw and palette rectangles.
        byte_queue = '{{CTRL_FILL, 4'hF}, 8'h00, 8'h00, 8'h00,
                       {CTRL_FILL, 4'h0}, 8'hFF, 8'hFF, 8'hFF,
                       8'h01, 8'hFF, 8'h00, 8'hAA,
                       8'h70, FILTER_PALETTE, 8'h01,
                       8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 8'hEF, 8'hA5,
                       8'h62, 8'h02, 8'h55, 8'h0F, 8'hF0};

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_regs(4095, 4095, 3, 2, 4096, 255);
                1: set_regs(0, 0, 1, 1, 1, 0);
                2: set_regs(7, 3, 4095, 1, 4096, 12);
                3: set_regs(4095, 0, 1, 4095, 1024, 40);
                default: set_regs($urandom_range(4095), $urandom_range(4095),
                                  $urandom_range(1, 10), $urandom_range(1, 4),
                                  $urandom_range(1, 4096), $urandom_range(255));
            endcase
            calm = (p == 5);
            while (byte_queue.size() < 60) queue_rect();
        end

        // Only one error can be seen, since the parser halts until reset.
        drain();
        byte_queue.push_back({($urandom_range(1) == 0) ? CTRL_JPEG
                              : 4'($urandom_range(10, 15)), 4'($urandom)});
        push_random(8);
        drain();
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> tight_rect_byte_decoder_top.f
rtl/core/trbd_pkg.sv
rtl/core/trbd_ram.sv
rtl/core/trbd_queue.sv
rtl/core/trbd_front.sv
rtl/core/trbd_back.sv
rtl/core/tight_rect_byte_decoder_top.sv
bench/tb.sv
